// ----- rtl/rlfp_pkg.sv -----
package rlfp_pkg;

  // result status codes
  localparam logic [2:0] STATUS_PENDING  = 3'd0;
  localparam logic [2:0] STATUS_SYNC_DROP = 3'd1;
  localparam logic [2:0] STATUS_LEN_ERR  = 3'd2;
  localparam logic [2:0] STATUS_CRC_ERR  = 3'd3;
  localparam logic [2:0] STATUS_GOOD     = 3'd4;

  // configuration register indexes
  localparam logic CFG_IDX_SYNC_ADDRESS   = 1'b0;
  localparam logic CFG_IDX_MAX_LENGTH     = 1'b1;

  // length byte bounds and crc polynomial
  localparam logic [7:0] LEN_MIN       = 8'd2;
  localparam int         LEN_MAX       = 62;
  localparam logic [7:0] CRC_POLY      = 8'hD5;
  localparam logic [7:0] SYNC_ADDR_RST = 8'd200;
  localparam logic [5:0] MAX_LEN_RST   = 6'd62;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } rlfp_state_t;

  // one byte of crc-8, msb first, no final xor
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/rlfp_ram.sv -----
module rlfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rc_link_frame_parser_crc8.sv -----
// rc link frame parser with crc-8 check
// input channel: one received serial byte per transaction (in_valid, in_stall,
//   in_rx_byte). the parser hunts for the sync address, checks the length
//   byte, buffers the frame in a single-port-write ram and checks crc-8
//   (poly 0xd5, start 0) over type and payload against the final byte
// result channel: out_valid, out_stall and one port per field. every byte
//   that does not complete a good frame gives one status result; a good frame
//   gives one result per payload byte (or one result for an empty payload)
// timing: a status result is registered and shows in the cycle after its byte
//   is accepted. each payload byte of a good frame is read from the ram in
//   the read state, then loaded into the output register in the load state
// throughput: one byte per cycle outside of payload readout and output stalls
// stall: a held result holds the output register; the input is stalled while
//   the output register is full and stalled, and during payload readout
// reset: synchronous, active low; clears the hunt state and all four 32-bit
//   counters and restores sync address 200 and max length byte 62. the frame
//   ram needs no clearing, entries are read only after being written
// configuration: cfg_write_en with cfg_index; the user must write only while
//   the parser idles, which the block itself does not enforce
module rc_link_frame_parser_crc8 #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // received bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_frame_type,
  output logic [5:0]  out_payload_count,
  output logic [5:0]  out_payload_index,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  output logic [31:0] out_sync_drops,
  output logic [31:0] out_length_errors,
  output logic [31:0] out_crc_errors,
  output logic [31:0] out_good_frames
);

  import rlfp_pkg::*;

  localparam int AW = $clog2(MAX_FRAME_BYTES);
  // effective ceiling on the length byte from frame buffer size
  localparam int LimitCap = (MAX_FRAME_BYTES - 2 < LEN_MAX) ? MAX_FRAME_BYTES - 2 : LEN_MAX;
  localparam logic [7:0] LIMIT_CAP = 8'(LimitCap);
  localparam logic [6:0] MAX_POS   = 7'(MAX_FRAME_BYTES);

  // control and configuration state
  rlfp_state_t state_r, state_nxt;
  logic [7:0]  sync_addr_r;
  logic [5:0]  max_len_r;
  logic [6:0]  pos_r, pos_nxt;
  logic [6:0]  size_r, size_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [5:0]  plen_r, plen_nxt;
  logic [5:0]  idx_r, idx_nxt;

  // wrapping event counters
  logic [31:0] sync_drops_r, sync_drops_nxt;
  logic [31:0] len_errs_r, len_errs_nxt;
  logic [31:0] crc_errs_r, crc_errs_nxt;
  logic [31:0] good_frames_r, good_frames_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [7:0]  out_type_r, out_type_nxt;
  logic [5:0]  out_plen_r, out_plen_nxt;
  logic [5:0]  out_idx_r, out_idx_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  // frame ram port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic       in_accept;
  logic       out_free;
  logic [7:0] limit_c;
  logic [6:0] pos_inc_c;
  logic [6:0] rd_addr_c;
  logic       run_last_c;

  rlfp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // input waits while a result sits stalled or the payload is being read out
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  // length limit: smallest of register, 62 and buffer size minus two
  assign limit_c    = ({2'b00, max_len_r} < LIMIT_CAP) ? {2'b00, max_len_r} : LIMIT_CAP;
  assign pos_inc_c  = pos_r + 7'd1;
  // payload starts after address, length and type
  assign rd_addr_c  = {1'b0, idx_r} + 7'd3;
  assign ram_raddr  = rd_addr_c[AW-1:0];
  assign run_last_c = ({1'b0, idx_r} + 7'd1) == {1'b0, plen_r};

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    size_nxt        = size_r;
    crc_nxt         = crc_r;
    type_nxt        = type_r;
    plen_nxt        = plen_r;
    idx_nxt         = idx_r;
    sync_drops_nxt  = sync_drops_r;
    len_errs_nxt    = len_errs_r;
    crc_errs_nxt    = crc_errs_r;
    good_frames_nxt = good_frames_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_type_nxt    = out_type_r;
    out_plen_nxt    = out_plen_r;
    out_idx_nxt     = out_idx_r;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_r[AW-1:0];
    ram_re          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          // status result unless a good frame with payload starts a readout
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_PENDING;
          out_type_nxt   = 8'd0;
          out_plen_nxt   = 6'd0;
          out_idx_nxt    = 6'd0;
          out_byte_nxt   = 8'd0;
          out_last_nxt   = 1'b1;

          if (pos_r == 7'd0) begin
            // hunting for the address byte
            if (in_rx_byte != sync_addr_r) begin
              sync_drops_nxt = sync_drops_r + 32'd1;
              out_status_nxt = STATUS_SYNC_DROP;
            end else begin
              ram_we  = 1'b1;
              pos_nxt = 7'd1;
            end
          end else if (pos_r == 7'd1) begin
            // length byte
            if (in_rx_byte < LEN_MIN || in_rx_byte > limit_c) begin
              len_errs_nxt   = len_errs_r + 32'd1;
              out_status_nxt = STATUS_LEN_ERR;
              size_nxt       = 7'd0;
              if (in_rx_byte == sync_addr_r) begin
                // bad length that is itself the address starts a new frame
                ram_we    = 1'b1;
                ram_waddr = '0;
                pos_nxt   = 7'd1;
              end else begin
                pos_nxt = 7'd0;
              end
            end else begin
              ram_we   = 1'b1;
              pos_nxt  = 7'd2;
              size_nxt = in_rx_byte[6:0] + 7'd2;
              crc_nxt  = 8'd0;
            end
          end else if (pos_r >= size_r || pos_r >= MAX_POS) begin
            // overrun guard
            len_errs_nxt   = len_errs_r + 32'd1;
            out_status_nxt = STATUS_LEN_ERR;
            pos_nxt        = 7'd0;
            size_nxt       = 7'd0;
          end else begin
            ram_we = 1'b1;
            if (pos_r == 7'd2) begin
              type_nxt = in_rx_byte;
            end
            if (pos_inc_c != size_r) begin
              crc_nxt = crc_feed(crc_r, in_rx_byte);
              pos_nxt = pos_inc_c;
            end else begin
              // final byte carries the crc
              pos_nxt  = 7'd0;
              size_nxt = 7'd0;
              if (in_rx_byte != crc_r) begin
                crc_errs_nxt   = crc_errs_r + 32'd1;
                out_status_nxt = STATUS_CRC_ERR;
              end else begin
                good_frames_nxt = good_frames_r + 32'd1;
                out_status_nxt  = STATUS_GOOD;
                out_type_nxt    = type_r;
                if (size_r != 7'd4) begin
                  // payload run comes from the ram
                  out_valid_nxt = 1'b0;
                  plen_nxt      = 6'(size_r - 7'd4);
                  idx_nxt       = 6'd0;
                  state_nxt     = ST_READ;
                end
              end
            end
          end
        end
      end

      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_LOAD;
      end

      ST_LOAD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_GOOD;
          out_type_nxt   = type_r;
          out_plen_nxt   = plen_r;
          out_idx_nxt    = idx_r;
          out_byte_nxt   = ram_rdata;
          out_last_nxt   = run_last_c;
          if (run_last_c) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 6'd1;
            state_nxt = ST_READ;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      sync_addr_r   <= SYNC_ADDR_RST;
      max_len_r     <= MAX_LEN_RST;
      pos_r         <= 7'd0;
      size_r        <= 7'd0;
      crc_r         <= 8'd0;
      sync_drops_r  <= 32'd0;
      len_errs_r    <= 32'd0;
      crc_errs_r    <= 32'd0;
      good_frames_r <= 32'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      size_r        <= size_nxt;
      crc_r         <= crc_nxt;
      sync_drops_r  <= sync_drops_nxt;
      len_errs_r    <= len_errs_nxt;
      crc_errs_r    <= crc_errs_nxt;
      good_frames_r <= good_frames_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_IDX_SYNC_ADDRESS: sync_addr_r <= cfg_data;
          CFG_IDX_MAX_LENGTH:   max_len_r   <= cfg_data[5:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    type_r       <= type_nxt;
    plen_r       <= plen_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_type_r   <= out_type_nxt;
    out_plen_r   <= out_plen_nxt;
    out_idx_r    <= out_idx_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_frame_type     = out_type_r;
  assign out_payload_count  = out_plen_r;
  assign out_payload_index  = out_idx_r;
  assign out_payload_byte   = out_byte_r;
  assign out_last           = out_last_r;
  // counters move only on accepted bytes, which a held result blocks
  assign out_sync_drops     = sync_drops_r;
  assign out_length_errors  = len_errs_r;
  assign out_crc_errors     = crc_errs_r;
  assign out_good_frames    = good_frames_r;

endmodule
